[rtl/core/sbusd_pkg.sv]
// Shared constants, codes and types of the SBUS frame decoder.
// No dependencies; every other file of the block but sbusd_in_if imports this package.
package sbusd_pkg;

  // Frame geometry
  localparam int NUM_CHANNELS = 7;
  localparam int OUT_CHANS    = 7;
  localparam int CHAN_W       = 11;
  localparam int FRAME_LEN    = 24;
  localparam int FLAG_IDX     = 22;
  // The end byte is checked as it arrives, so only the bytes before it are stored.
  localparam int STORE_LEN    = FRAME_LEN - 1;
  localparam int IDX_W        = $clog2(FRAME_LEN);
  localparam int ELAPSED_W    = 17;
  localparam int TIMEOUT_W    = 16;
  localparam int FAIL_W       = 32;
  localparam int STATUS_W     = 3;

  // Byte values and flag masks
  localparam logic [7:0] HDR_BYTE      = 8'h0F;
  localparam logic [7:0] END_BYTE      = 8'h00;
  localparam logic [7:0] FLAG_FAILSAFE = 8'h08;
  localparam logic [7:0] FLAG_LOST     = 8'h04;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd4000;

  // Word kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_VALID    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAILSAFE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_LOST     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_END  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 3'd4;

  // Parser states
  localparam logic ST_SCAN    = 1'b0;
  localparam logic ST_COLLECT = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [STORE_LEN-1:0][7:0] store_t;

  typedef struct packed {
    logic [STATUS_W-1:0]          status;
    chan_t [OUT_CHANS-1:0]        chan;
    logic [FAIL_W-1:0]            fail_total;
  } sbusd_result_t;

endpackage

[rtl/core/sbusd_in_if.sv]
// Input word channel of the SBUS frame decoder: received bytes and ticks.
// Depends on no other file; it uses nothing from sbusd_pkg.
interface sbusd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

[rtl/core/sbusd_out_if.sv]
// Result channel of the SBUS frame decoder: status, held channels, fail count.
// Depends on sbusd_pkg.
interface sbusd_out_if;
  import sbusd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  chan_t               chan0;
  chan_t               chan1;
  chan_t               chan2;
  chan_t               chan3;
  chan_t               chan4;
  chan_t               chan5;
  chan_t               chan6;
  logic [FAIL_W-1:0]   fail_total;

  modport source (output valid, output status, output chan0, output chan1, output chan2,
                  output chan3, output chan4, output chan5, output chan6,
                  output fail_total, input ready);
  modport sink   (input valid, input status, input chan0, input chan1, input chan2,
                  input chan3, input chan4, input chan5, input chan6,
                  input fail_total, output ready);
endinterface

[rtl/core/sbusd_unpack.sv]
// Channel unpacker: slices the stored frame bytes into 11-bit channels.
// Depends on sbusd_pkg.
module sbusd_unpack (
  input  sbusd_pkg::store_t                        store,
  output sbusd_pkg::chan_t [sbusd_pkg::NUM_CHANNELS-1:0] chans
);
  import sbusd_pkg::*;

  logic [STORE_LEN*8-1:0] frame_bits;

  // Byte 0 sits in the low bits, so channels are little-endian bit fields.
  assign frame_bits = store;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    assign chans[c] = frame_bits[c*CHAN_W +: CHAN_W];
  end

endmodule

[rtl/core/sbusd_core.sv]
// Frame parser: header scan, byte collection, timeout, status and held channels.
// Depends on sbusd_pkg and sbusd_unpack.
module sbusd_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbusd_pkg::TIMEOUT_W-1:0]  cfg_wdata,
  input  logic                             step,
  input  logic                             cmd,
  input  logic [7:0]                       data_byte,
  output logic                             res_valid,
  output sbusd_pkg::sbusd_result_t         res
);
  import sbusd_pkg::*;

  logic                   state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0]   elapsed_inc;
  logic [TIMEOUT_W-1:0]   timeout_r;
  logic [FAIL_W-1:0]      fail_r, fail_nxt;
  store_t                 store_r;
  chan_t [NUM_CHANNELS-1:0] held_r;
  chan_t [NUM_CHANNELS-1:0] unpacked;
  logic                   store_we;
  logic                   count_fail;
  logic                   update_held;
  logic [STATUS_W-1:0]    status;

  sbusd_unpack u_unpack (
    .store (store_r),
    .chans (unpacked)
  );

  assign elapsed_inc = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;

  // Next-state logic for one word.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    elapsed_nxt = elapsed_r;
    res_valid   = 1'b0;
    status      = STATUS_VALID;
    store_we    = 1'b0;
    count_fail  = 1'b0;
    update_held = 1'b0;
    unique case (state_r)
      ST_SCAN: begin
        if (step && cmd == CMD_BYTE && data_byte == HDR_BYTE) begin
          state_nxt   = ST_COLLECT;
          idx_nxt     = '0;
          elapsed_nxt = '0;
        end
      end
      ST_COLLECT: begin
        if (step && cmd == CMD_TICK) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > {1'b0, timeout_r}) begin
            state_nxt  = ST_SCAN;
            idx_nxt    = '0;
            res_valid  = 1'b1;
            status     = STATUS_TIMEOUT;
            count_fail = 1'b1;
          end
        end else if (step) begin
          if (idx_r == IDX_W'(FRAME_LEN - 1)) begin
            // Last byte: judge the frame while the end byte is on the input.
            state_nxt = ST_SCAN;
            idx_nxt   = '0;
            res_valid = 1'b1;
            priority if (data_byte != END_BYTE) begin
              status     = STATUS_BAD_END;
              count_fail = 1'b1;
            end else if ((store_r[FLAG_IDX] & FLAG_FAILSAFE) != '0) begin
              status = STATUS_FAILSAFE;
            end else if ((store_r[FLAG_IDX] & FLAG_LOST) != '0) begin
              status = STATUS_LOST;
            end else begin
              status      = STATUS_VALID;
              update_held = 1'b1;
            end
          end else begin
            store_we = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_SCAN;
      end
    endcase
  end

  // Saturating failure counter.
  assign fail_nxt = (count_fail && fail_r != '1) ? fail_r + 1'b1 : fail_r;

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_SCAN;
      idx_r     <= '0;
      elapsed_r <= '0;
      timeout_r <= TIMEOUT_RESET;
      fail_r    <= '0;
      held_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      elapsed_r <= elapsed_nxt;
      fail_r    <= fail_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (update_held) begin
        held_r <= unpacked;
      end
    end
  end

  // Frame byte store; every byte is written before it is read.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[idx_r] <= data_byte;
    end
  end

  // Result word: held channels as they stand after this frame.
  assign res.status     = status;
  assign res.fail_total = fail_nxt;
  for (genvar j = 0; j < OUT_CHANS; j++) begin : g_out
    if (j < NUM_CHANNELS) begin : g_used
      assign res.chan[j] = update_held ? unpacked[j] : held_r[j];
    end else begin : g_zero
      assign res.chan[j] = '0;
    end
  end

endmodule

[rtl/core/sbus_frame_decoder_unit.sv]
// Top level of the SBUS frame decoder: input register, parser core, result register.
// Depends on sbusd_pkg, sbusd_in_if, sbusd_out_if and sbusd_core.
//
// Usage:
//   in_bus carries words: cmd 0 is a received serial byte, cmd 1 a 1 ms tick.
//   out_bus carries one result per finished or abandoned frame: a status,
//   the seven held channels and a saturating count of failed frames.
//   cfg_we/cfg_wdata write the timeout in ticks (reset 4000); write it only
//   while the decoder is idle.
// Timing:
//   A word accepted into the input register is parsed once the result
//   register is free or draining, and its result, if any, is loaded into the
//   output register that drives out_bus.valid. One word is taken every cycle
//   while no result waits on out_bus.ready; the single parse pass from input
//   register to output register sets that rate.
// Reset (rst_n, synchronous, active low):
//   The decoder scans for a header, channels and fail count are zero and
//   both registers are empty.
// Stalls:
//   While a result waits on out_bus.ready, words that cause no result still
//   wait in the input register; in_bus.ready drops once that register is
//   full and cannot drain.
module sbus_frame_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  sbusd_in_if.sink                         in_bus,
  sbusd_out_if.source                      out_bus,
  input  logic                             cfg_we,
  input  logic [sbusd_pkg::TIMEOUT_W-1:0]  cfg_wdata
);
  import sbusd_pkg::*;

  logic          in_valid_r, in_valid_nxt;
  logic          in_cmd_r;
  logic [7:0]    in_byte_r;
  logic          out_valid_r, out_valid_nxt;
  sbusd_result_t out_r;
  logic          consume;
  logic          res_valid;
  sbusd_result_t res;

  // A held word is parsed when the result register is free or draining.
  assign consume      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || consume;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_bus.valid && in_bus.ready) begin
      in_valid_nxt = 1'b1;
    end else if (consume) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume) begin
      out_valid_nxt = res_valid;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_cmd_r  <= in_bus.cmd;
      in_byte_r <= in_bus.data_byte;
    end
  end

  sbusd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (consume),
    .cmd       (in_cmd_r),
    .data_byte (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res_valid) begin
      out_r <= res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_r.status;
  assign out_bus.chan0      = out_r.chan[0];
  assign out_bus.chan1      = out_r.chan[1];
  assign out_bus.chan2      = out_r.chan[2];
  assign out_bus.chan3      = out_r.chan[3];
  assign out_bus.chan4      = out_r.chan[4];
  assign out_bus.chan5      = out_r.chan[5];
  assign out_bus.chan6      = out_r.chan[6];
  assign out_bus.fail_total = out_r.fail_total;

  // The input side only backs up behind a pending result.
  a_ready_low_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_valid_r)
    else $error("input stalled with no result pending");

  // A parsed word that yields a result always reaches the output register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && res_valid) |=> out_valid_r)
    else $error("result of a parsed word was dropped");

  // Only defined status codes are ever presented.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status <= STATUS_TIMEOUT))
    else $error("undefined status code on the output");

endmodule
